@@ rtl/bbia_pkg.sv @@
`default_nettype none
package bbia_pkg;
    typedef enum logic [1:0] {
        K_FIND = 2'd0,
        K_SET  = 2'd1,
        K_CLR  = 2'd2,
        K_NOP  = 2'd3
    } t_kind;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_RANGE = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    localparam int unsigned BLOCK_RESERVED = 132;
    localparam int unsigned INODE_RESERVED = 1;
    localparam int unsigned BLOCK_GROUP_RESET = 892;
    localparam int unsigned INODE_GROUP_RESET = 1024;
    localparam int unsigned BLOCK_TOTAL_RESET = 8168;
    localparam int unsigned INODE_TOTAL_RESET = 8168;

    typedef struct packed {
        logic [1:0] kind;
        logic       map_select;
        logic [2:0] group;
        logic [9:0] bit_index;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [10:0] found_index;
        logic [10:0] group_free;
        logic [13:0] total_free;
    } t_rsp;
endpackage
`default_nettype wire

@@ rtl/bbia_if.sv @@
`default_nettype none
interface bbia_req_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic       map_select;
    logic [2:0] group;
    logic [9:0] bit_index;
    modport source (output valid, kind, map_select, group, bit_index, input ready);
    modport sink (input valid, kind, map_select, group, bit_index, output ready);
endinterface

interface bbia_rsp_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [10:0] found_index;
    logic [10:0] group_free;
    logic [13:0] total_free;
    modport source (output valid, status, found_index, group_free, total_free, input ready);
    modport sink (input valid, status, found_index, group_free, total_free, output ready);
endinterface
`default_nettype wire

@@ rtl/bbia_front.sv @@
`default_nettype none
// Request queue: two entries between the port and the bitmap engine.
module bbia_front
    import bbia_pkg::*;
(
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_valid,
    input  wire  i_ready,
    output t_req o_req
);
    t_req       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready = (r_cnt != 2'd2);
    assign o_valid = (r_cnt != 2'd0);
    assign o_req   = r_q[r_rp];
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;

    always_ff @(posedge i_clk) begin
        if (push) r_q[r_wp] <= i_req;
        if (!i_rst_n) begin
            r_wp <= 1'b0; r_rp <= 1'b0; r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_cnt != 2'd3)
        else $error("queue count overflow");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd2 && !pop) |=> r_cnt == 2'd2)
        else $error("full queue lost an item");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == 2'd0 && !push) |=> !o_valid)
        else $error("empty queue shows an item");
endmodule
`default_nettype wire

@@ rtl/bbia_engine.sv @@
`default_nettype none
// Bitmap engine. Each map is one memory of GROUPS*WPG words; a clearing pass
// after reset writes the reset pattern. A find reads one word a cycle.
module bbia_engine
    import bbia_pkg::*;
#(
    parameter int GROUPS = 8,
    parameter int BITS_PER_GROUP = 1024,
    parameter int WORD_BITS = 64
) (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_valid,
    output logic o_ready,
    input  t_req i_req,
    output logic o_valid,
    input  wire  i_ready,
    output t_rsp o_rsp
);
    localparam int WPG = (BITS_PER_GROUP + WORD_BITS - 1) / WORD_BITS;
    localparam int DEPTH = GROUPS * WPG;
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int WW = (WPG > 1) ? $clog2(WPG) : 1;
    localparam int BW = (WORD_BITS > 1) ? $clog2(WORD_BITS) : 1;
    localparam int GW = (GROUPS > 1) ? $clog2(GROUPS) : 1;
    localparam logic [13:0] TOTAL_LIMIT = 14'(GROUPS * BITS_PER_GROUP);
    localparam logic [10:0] GRP_LIMIT = 11'(BITS_PER_GROUP);

    typedef enum logic [5:0] {
        S_INIT  = 6'b000001,
        S_IDLE  = 6'b000010,
        S_READ  = 6'b000100,
        S_SCAN  = 6'b001000,
        S_MARK  = 6'b010000,
        S_OUT   = 6'b100000
    } t_state;

    logic [WORD_BITS-1:0] r_bmem [DEPTH];
    logic [WORD_BITS-1:0] r_imem [DEPTH];
    logic [WORD_BITS-1:0] r_rd;
    logic [10:0] r_bgf [GROUPS];
    logic [10:0] r_igf [GROUPS];
    logic [13:0] r_btf, r_itf;
    t_state r_st;
    t_req   r_req;
    t_rsp   r_rsp;
    logic [AW-1:0] r_addr;
    logic [WW:0]   r_wcnt;

    logic [WORD_BITS-1:0] init_b, init_i, wval, mask;
    logic [AW-1:0] base, maddr, in_base;
    logic [BW-1:0] zpos;
    logic zfound;
    logic grp_ok, idx_ok;
    logic set_hit, clr_hit;
    logic [10:0] gf, gf_new;
    logic [13:0] tf, tf_new;

    assign grp_ok = 32'(r_req.group) < GROUPS;
    assign idx_ok = 32'(r_req.bit_index) < BITS_PER_GROUP;
    assign base   = AW'(32'(r_req.group) * WPG);
    assign maddr  = AW'(32'(base) + 32'(r_req.bit_index) / WORD_BITS);
    assign in_base = AW'(32'(i_req.group) * WPG);
    assign mask   = {{(WORD_BITS-1){1'b0}}, 1'b1}
                    << (WORD_BITS - 1 - 32'(r_req.bit_index) % WORD_BITS);
    assign gf     = r_req.map_select ? r_igf[GW'(r_req.group)] : r_bgf[GW'(r_req.group)];
    assign tf     = r_req.map_select ? r_itf : r_btf;

    // Reset pattern of the word being cleared; word position within group.
    always_comb begin
        int wi;
        wi = 32'(r_addr) % WPG;
        for (int b = 0; b < WORD_BITS; b++) begin
            init_b[WORD_BITS-1-b] = (wi * WORD_BITS + b) < BLOCK_RESERVED;
            init_i[WORD_BITS-1-b] = (wi * WORD_BITS + b) < INODE_RESERVED;
        end
    end

    // Leftmost zero within the word; bits past the group end count as used.
    always_comb begin
        zfound = 1'b0;
        zpos = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            if (!r_rd[b] && ((32'(r_wcnt) * WORD_BITS + (WORD_BITS - 1 - b))
                    < BITS_PER_GROUP)) begin
                zfound = 1'b1;
                zpos = BW'(WORD_BITS - 1 - b);
            end
        end
    end

    assign wval = (r_req.kind == K_SET) ? (r_rd | mask) : (r_rd & ~mask);

    // Counts move only when the addressed bit really changes.
    assign set_hit = idx_ok && r_req.kind == K_SET && (r_rd & mask) == '0;
    assign clr_hit = idx_ok && r_req.kind == K_CLR && (r_rd & mask) != '0;

    always_comb begin
        gf_new = gf;
        tf_new = tf;
        if (set_hit) begin
            gf_new = (gf != '0) ? gf - 1'b1 : gf;
            tf_new = (tf != '0) ? tf - 1'b1 : tf;
        end else if (clr_hit) begin
            gf_new = (gf >= GRP_LIMIT) ? GRP_LIMIT : gf + 1'b1;
            tf_new = (tf >= TOTAL_LIMIT) ? TOTAL_LIMIT : tf + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_INIT) begin
            r_bmem[r_addr] <= init_b;
            r_imem[r_addr] <= init_i;
        end else if (r_st == S_MARK && grp_ok && idx_ok) begin
            if (r_req.map_select) r_imem[maddr] <= wval;
            else r_bmem[maddr] <= wval;
        end
        if (r_st == S_READ || r_st == S_SCAN)
            r_rd <= r_req.map_select ? r_imem[r_addr] : r_bmem[r_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_INIT;
            r_addr <= '0;
            r_btf <= 14'(BLOCK_TOTAL_RESET);
            r_itf <= 14'(INODE_TOTAL_RESET);
            for (int g = 0; g < GROUPS; g++) begin
                r_bgf[g] <= 11'(BLOCK_GROUP_RESET);
                r_igf[g] <= 11'(INODE_GROUP_RESET);
            end
        end else begin
            unique case (r_st)
                S_INIT: begin
                    if (32'(r_addr) == DEPTH - 1) r_st <= S_IDLE;
                    else r_addr <= r_addr + 1'b1;
                end
                S_IDLE: begin
                    if (i_valid) begin
                        r_req <= i_req;
                        // Point at the first word of a find, or the word of a mark.
                        r_addr <= (i_req.kind == K_FIND) ? in_base
                                  : AW'(32'(in_base) + 32'(i_req.bit_index) / WORD_BITS);
                        r_st <= S_READ;
                    end
                end
                S_READ: begin
                    r_wcnt <= '0;
                    if (!grp_ok) begin
                        r_rsp <= '{status: ST_RANGE, found_index: '0,
                                   group_free: '0, total_free: tf};
                        r_st <= S_OUT;
                    end else if (r_req.kind == K_FIND) begin
                        r_rsp <= '0;
                        r_addr <= r_addr + 1'b1;
                        r_st <= S_SCAN;
                    end else if (r_req.kind == K_NOP) begin
                        r_rsp <= '{status: ST_OK, found_index: '0,
                                   group_free: gf, total_free: tf};
                        r_st <= S_OUT;
                    end else begin
                        r_st <= S_MARK;
                    end
                end
                S_SCAN: begin
                    r_rsp.group_free <= gf;
                    r_rsp.total_free <= tf;
                    if (zfound) begin
                        r_rsp.found_index <= 11'(32'(r_wcnt) * WORD_BITS + 32'(zpos)
                                                 + (r_req.map_select ? 1 : 0));
                        r_st <= S_OUT;
                    end else if (32'(r_wcnt) == WPG - 1) begin
                        r_rsp.status <= ST_FULL;
                        r_st <= S_OUT;
                    end else begin
                        r_wcnt <= r_wcnt + 1'b1;
                        r_addr <= r_addr + 1'b1;
                    end
                end
                S_MARK: begin
                    r_rsp <= '{status: idx_ok ? ST_OK : ST_RANGE, found_index: '0,
                               group_free: gf_new, total_free: tf_new};
                    if (set_hit || clr_hit) begin
                        if (r_req.map_select) begin
                            r_igf[GW'(r_req.group)] <= gf_new;
                            r_itf <= tf_new;
                        end else begin
                            r_bgf[GW'(r_req.group)] <= gf_new;
                            r_btf <= tf_new;
                        end
                    end
                    r_st <= S_OUT;
                end
                S_OUT: begin
                    if (i_ready) r_st <= S_IDLE;
                end
                default: r_st <= S_INIT;
            endcase
        end
    end

    assign o_ready = (r_st == S_IDLE);
    assign o_valid = (r_st == S_OUT);
    assign o_rsp   = r_rsp;

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_rsp))
        else $error("result changed while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_btf <= TOTAL_LIMIT && r_itf <= TOTAL_LIMIT)
        else $error("total free count beyond limit");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_SCAN) |-> 32'(r_wcnt) < WPG)
        else $error("scan ran past group end");
endmodule
`default_nettype wire

@@ rtl/bitmap_block_inode_allocator_unit.sv @@
`default_nettype none
// Bitmap allocator for data blocks and inodes.
// Request channel (i_req): kind, map_select, group, bit_index. Response
// channel (o_rsp): status, found_index, group_free, total_free. Both use
// valid/ready; an item moves when both are high.
// A two-entry queue takes requests while the engine works. Each map is held
// in one memory of 64-bit words read one word per cycle.
// A mark passes through the read, mark and output states; a find passes
// through the read state, then scans one word at a time until it finds a free
// bit or has checked all sixteen words of the group, then outputs. The engine
// takes a new request only after the receiver has taken the previous result.
// After reset the engine runs a clearing pass over all GROUPS * words-per-group
// words (128 at the defaults) to load the reserved bits; requests wait in
// the queue meanwhile. While the receiver stalls the result holds and the
// engine waits; the queue still takes up to two requests.
module bitmap_block_inode_allocator_unit
    import bbia_pkg::*;
#(
    parameter int GROUPS = 8,
    parameter int BITS_PER_GROUP = 1024,
    parameter int WORD_BITS = 64
) (
    input  wire        i_clk,
    input  wire        i_rst_n,
    bbia_req_if.sink   i_req,
    bbia_rsp_if.source o_rsp
);
    t_req in_req, q_req;
    t_rsp rsp;
    logic q_valid, q_ready;

    assign in_req = '{kind: i_req.kind, map_select: i_req.map_select,
                      group: i_req.group, bit_index: i_req.bit_index};

    bbia_front u_front (
        .i_clk, .i_rst_n,
        .i_valid(i_req.valid), .o_ready(i_req.ready), .i_req(in_req),
        .o_valid(q_valid), .i_ready(q_ready), .o_req(q_req)
    );

    bbia_engine #(.GROUPS(GROUPS), .BITS_PER_GROUP(BITS_PER_GROUP),
                  .WORD_BITS(WORD_BITS)) u_engine (
        .i_clk, .i_rst_n,
        .i_valid(q_valid), .o_ready(q_ready), .i_req(q_req),
        .o_valid(o_rsp.valid), .i_ready(o_rsp.ready), .o_rsp(rsp)
    );

    assign o_rsp.status      = rsp.status;
    assign o_rsp.found_index = rsp.found_index;
    assign o_rsp.group_free  = rsp.group_free;
    assign o_rsp.total_free  = rsp.total_free;
endmodule
`default_nettype wire

@@ sim/tb_bbia_if.sv @@
`timescale 1ns / 100ps
// The block's interfaces are compiled from the RTL folder; this file only
// holds the item types that the testbench passes between its processes.
package tb_bbia_types_pkg;
    import bbia_pkg::*;

    typedef struct {
        t_kind      kind;
        logic       map_select;
        logic [2:0] group;
        logic [9:0] bit_index;
    } t_alloc_req;

    typedef struct {
        logic [1:0]  status;
        logic [10:0] found_index;
        logic [10:0] group_free;
        logic [13:0] total_free;
    } t_alloc_rsp;
endpackage

@@ sim/tb_bitmap_block_inode_allocator_unit.sv @@
`timescale 1ns / 100ps
module tb_bitmap_block_inode_allocator_unit;
    import bbia_pkg::*;
    import tb_bbia_types_pkg::*;

    localparam int NUM_GROUPS = 8;
    localparam int GROUP_BITS = 1024;

    logic i_clk;
    logic i_rst_n;

    bbia_req_if req_if ();
    bbia_rsp_if rsp_if ();

    bitmap_block_inode_allocator_unit u_top (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_if.sink),
        .o_rsp  (rsp_if.source)
    );

    // Shadow allocator state: index [map][group], bit 0 of a group is index 0.
    logic [GROUP_BITS-1:0] shadow_map [2][NUM_GROUPS];
    int unsigned           shadow_group_free [2][NUM_GROUPS];
    int unsigned           shadow_total_free [2];

    t_alloc_req  pending_reqs [$];
    t_alloc_rsp  expected_rsps [$];
    int          error_count;
    bit          quiet_phase;
    int          hold_off_cycles;
    int          drv_gap;
    int          mon_gap;
    bit          req_fire;

    initial begin
        i_clk = 1'b0;
        forever #1 i_clk = ~i_clk;
    end

    initial begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("Mismatch %s: got %0d, expected %0d at %0t", what, got, want, $time);
        error_count++;
    endtask

    function automatic void reset_shadow();
        for (int m = 0; m < 2; m++) begin
            for (int g = 0; g < NUM_GROUPS; g++) begin
                shadow_map[m][g] = '0;
                for (int b = 0; b < ((m == 0) ? BLOCK_RESERVED : INODE_RESERVED); b++)
                    shadow_map[m][g][b] = 1'b1;
                shadow_group_free[m][g] = (m == 0) ? BLOCK_GROUP_RESET : INODE_GROUP_RESET;
            end
        end
        shadow_total_free[0] = BLOCK_TOTAL_RESET;
        shadow_total_free[1] = INODE_TOTAL_RESET;
    endfunction

    function automatic t_alloc_rsp allocate_step(input t_alloc_req r);
        t_alloc_rsp rsp;
        int         m;
        int         g;
        m = r.map_select;
        g = r.group;
        rsp.status = ST_OK;
        rsp.found_index = '0;
        case (r.kind)
            K_FIND: begin
                rsp.status = ST_FULL;
                for (int b = 0; b < GROUP_BITS; b++) begin
                    if (!shadow_map[m][g][b]) begin
                        rsp.status = ST_OK;
                        rsp.found_index = 11'((m == 1) ? b + 1 : b);
                        break;
                    end
                end
            end
            K_SET: begin
                if (!shadow_map[m][g][r.bit_index]) begin
                    shadow_map[m][g][r.bit_index] = 1'b1;
                    if (shadow_group_free[m][g] > 0) shadow_group_free[m][g]--;
                    if (shadow_total_free[m] > 0) shadow_total_free[m]--;
                end
            end
            K_CLR: begin
                if (shadow_map[m][g][r.bit_index]) begin
                    shadow_map[m][g][r.bit_index] = 1'b0;
                    if (shadow_group_free[m][g] < GROUP_BITS) shadow_group_free[m][g]++;
                    if (shadow_total_free[m] < NUM_GROUPS * GROUP_BITS)
                        shadow_total_free[m]++;
                end
            end
            default: ;
        endcase
        rsp.group_free = 11'(shadow_group_free[m][g]);
        rsp.total_free = 14'(shadow_total_free[m]);
        return rsp;
    endfunction

    function automatic t_alloc_req make_req(input t_kind k, input int m, input int g,
                                            input int b);
        t_alloc_req r;
        r.kind = k;
        r.map_select = m[0];
        r.group = g[2:0];
        r.bit_index = b[9:0];
        return r;
    endfunction

    // Handshake check uses values sampled at the rising edge.
    always @(posedge i_clk) req_fire <= req_if.valid && req_if.ready && i_rst_n;

    // Driver: the prediction is made when the request is accepted.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_fire) begin
                expected_rsps.push_back(allocate_step(pending_reqs.pop_front()));
            end
            if (req_if.valid && !req_fire) begin
                // hold the current item
            end else if (drv_gap > 0) begin
                drv_gap--;
                req_if.valid <= 1'b0;
            end else if (pending_reqs.size() > 0 && !quiet_phase
                         && $urandom_range(0, 5) == 0) begin
                drv_gap = $urandom_range(1, 6);
                req_if.valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
                req_if.valid <= 1'b1;
                req_if.kind <= pending_reqs[0].kind;
                req_if.map_select <= pending_reqs[0].map_select;
                req_if.group <= pending_reqs[0].group;
                req_if.bit_index <= pending_reqs[0].bit_index;
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (hold_off_cycles > 0) begin
            hold_off_cycles--;
            rsp_if.ready <= 1'b0;
        end else if (mon_gap > 0) begin
            mon_gap--;
            rsp_if.ready <= 1'b0;
        end else if (!quiet_phase && $urandom_range(0, 5) == 0) begin
            mon_gap = $urandom_range(1, 6);
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
        end
    end

    // Monitor.
    always @(posedge i_clk) begin
        t_alloc_rsp want;
        if (i_rst_n && rsp_if.valid && rsp_if.ready) begin
            if (expected_rsps.size() == 0) begin
                report_mismatch("unexpected result", 1, 0);
            end else begin
                want = expected_rsps.pop_front();
                if (rsp_if.status !== want.status)
                    report_mismatch("status", rsp_if.status, want.status);
                if (rsp_if.found_index !== want.found_index)
                    report_mismatch("found_index", rsp_if.found_index, want.found_index);
                if (rsp_if.group_free !== want.group_free)
                    report_mismatch("group_free", rsp_if.group_free, want.group_free);
                if (rsp_if.total_free !== want.total_free)
                    report_mismatch("total_free", rsp_if.total_free, want.total_free);
            end
        end
    end

    task automatic wait_drained();
        while (pending_reqs.size() > 0 || req_if.valid || expected_rsps.size() > 0)
            @(posedge i_clk);
    endtask

    // Sequence that sets the first 64 bits of a group, runs a find, frees one of those bits and finds again.
    task automatic queue_fill_sequence(input int m, input int g);
        for (int b = 0; b < 64; b++) pending_reqs.push_back(make_req(K_SET, m, g, b));
        pending_reqs.push_back(make_req(K_FIND, m, g, 0));
        pending_reqs.push_back(make_req(K_CLR, m, g, $urandom_range(0, 63)));
        pending_reqs.push_back(make_req(K_FIND, m, g, 0));
    endtask

    initial begin
        int  m;
        int  g;
        int  b;
        t_kind k;
        bit  fill_done;
        error_count = 0;
        quiet_phase = 1'b0;
        fill_done = 1'b0;
        hold_off_cycles = 0;
        drv_gap = 0;
        mon_gap = 0;
        req_if.valid = 1'b0;
        req_if.kind = K_FIND;
        req_if.map_select = 1'b0;
        req_if.group = '0;
        req_if.bit_index = '0;
        rsp_if.ready = 1'b0;
        reset_shadow();
        i_rst_n = 1'b0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed: finds on fresh maps, extremes of index, no-op kind,
        // marks without a transition, and freeing a reserved bit.
        pending_reqs.push_back(make_req(K_FIND, 0, 0, 0));
        pending_reqs.push_back(make_req(K_FIND, 1, 7, 1023));
        pending_reqs.push_back(make_req(K_SET, 0, 7, 1023));
        pending_reqs.push_back(make_req(K_SET, 0, 7, 1023));
        pending_reqs.push_back(make_req(K_CLR, 0, 7, 1023));
        pending_reqs.push_back(make_req(K_CLR, 0, 7, 1023));
        pending_reqs.push_back(make_req(K_CLR, 0, 3, 0));
        pending_reqs.push_back(make_req(K_FIND, 0, 3, 0));
        pending_reqs.push_back(make_req(K_CLR, 1, 2, 0));
        pending_reqs.push_back(make_req(K_FIND, 1, 2, 0));
        pending_reqs.push_back(make_req(K_SET, 1, 2, 0));
        pending_reqs.push_back(make_req(K_SET, 1, 5, 1));
        pending_reqs.push_back(make_req(K_FIND, 1, 5, 0));
        pending_reqs.push_back(make_req(K_NOP, 1, 6, 1023));
        pending_reqs.push_back(make_req(K_NOP, 0, 0, 0));
        pending_reqs.push_back(make_req(K_CLR, 0, 1, 131));
        pending_reqs.push_back(make_req(K_FIND, 0, 1, 0));
        wait_drained();

        // The receiver holds off while requests keep coming, so the input stalls.
        hold_off_cycles = 300;
        for (int i = 0; i < 20; i++)
            pending_reqs.push_back(make_req(K_SET, $urandom_range(0, 1),
                                            $urandom_range(0, 7), $urandom_range(0, 1023)));
        wait_drained();

        // Random: mostly allocate-style sequences, the rest random noise.
        for (int i = 0; i < 550; ) begin
            if (i > 440) quiet_phase = 1'b1;
            m = $urandom_range(0, 1);
            g = $urandom_range(0, 7);
            case ($urandom_range(0, 3))
                0: begin
                    pending_reqs.push_back(make_req(K_FIND, m, g, $urandom_range(0, 1023)));
                    pending_reqs.push_back(make_req(K_SET, m, g, $urandom_range(0, 1023)));
                    i += 2;
                end
                1: begin
                    b = $urandom_range(0, 1023);
                    pending_reqs.push_back(make_req(K_SET, m, g, b));
                    pending_reqs.push_back(make_req(K_CLR, m, g, b));
                    pending_reqs.push_back(make_req(K_FIND, m, g, b));
                    i += 3;
                end
                2: begin
                    k = t_kind'($urandom_range(0, 3));
                    pending_reqs.push_back(make_req(k, m, g, $urandom_range(0, 1023)));
                    i += 1;
                end
                default: begin
                    b = $urandom_range(0, 1) ? $urandom_range(0, 140) : $urandom_range(0, 1023);
                    pending_reqs.push_back(make_req(
                        $urandom_range(0, 1) ? K_SET : K_CLR, m, g, b));
                    i += 1;
                end
            endcase
            if (pending_reqs.size() > 8) begin
                while (pending_reqs.size() >= 4) @(posedge i_clk);
            end
            if (i >= 300 && !fill_done) begin
                fill_done = 1'b1;
                queue_fill_sequence(m, g);
                wait_drained();
            end
        end
        wait_drained();
        repeat (40) @(posedge i_clk);
        if (error_count == 0 && expected_rsps.size() == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/bbia_pkg.sv
rtl/bbia_if.sv
rtl/bbia_front.sv
rtl/bbia_engine.sv
rtl/bitmap_block_inode_allocator_unit.sv
sim/tb_bbia_if.sv
sim/tb_bitmap_block_inode_allocator_unit.sv
